// ===== src/smre_pkg.sv =====
// Shared types, widths and constants for the stellar mass relation evaluator.
// Holds the fixed-point coefficients and the interpolation table; no dependencies.
package smre_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int TABLE_POINTS = 10;
  localparam int DATA_W       = 24;
  localparam int REL_W        = 4;
  localparam int CFG_IDX_W    = 3;

  // internal widths
  localparam int XW    = (FRAC_BITS > 20) ? FRAC_BITS + 7 : 27;
  localparam int P1W   = 2 * XW;
  localparam int YW    = P1W - FRAC_BITS;
  localparam int LO_W  = YW / 2;
  localparam int HI_W  = YW - LO_W;
  localparam int P2W   = DATA_W + XW;
  localparam int P3W   = DATA_W + YW;
  localparam int T3W   = P3W - FRAC_BITS;
  localparam int SUMW  = ((P2W > T3W) ? P2W : T3W) + 2;
  localparam int SH_W  = $clog2(FRAC_BITS + 1);
  localparam int SEG_W = $clog2(TABLE_POINTS);

  localparam longint ONE_Q  = 64'sd1 <<< FRAC_BITS;
  localparam longint HALF_Q = ONE_Q >>> 1;

  typedef enum logic [REL_W-1:0] {
    REL_TABLE   = 4'd0,
    REL_LIN_A   = 4'd1,
    REL_LIN_B   = 4'd2,
    REL_BROKEN  = 4'd3,
    REL_SHIFT3  = 4'd4,
    REL_PLAIN   = 4'd5,
    REL_AGE     = 4'd6,
    REL_SHIFT5  = 4'd7,
    REL_EDITED  = 4'd8,
    REL_QUAD    = 4'd9,
    REL_ROTATED = 4'd10,
    REL_SPLIT   = 4'd11
  } relation_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELECT    = 3'd0,
    CFG_INTERCEPT = 3'd1,
    CFG_SLOPE     = 3'd2,
    CFG_CURVE     = 3'd3,
    CFG_AGE       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] initial_mass;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] final_mass;
    logic                     mode_error;
  } out_item_t;

  // milli-units to fixed point, rounded to nearest
  function automatic longint kq(input longint milli);
    return (milli * ONE_Q + 500) / 1000;
  endfunction

  localparam logic signed [XW-1:0] Q_ONE   = XW'(ONE_Q);
  localparam logic signed [XW-1:0] Q_TWO   = XW'(2 * ONE_Q);
  localparam logic signed [XW-1:0] Q_THREE = XW'(3 * ONE_Q);
  localparam logic signed [XW-1:0] Q_FOUR  = XW'(4 * ONE_Q);
  localparam logic signed [XW-1:0] Q_FIVE  = XW'(5 * ONE_Q);
  localparam logic signed [XW-1:0] K27000  = XW'(kq(27000));
  localparam logic signed [XW-1:0] K2600   = XW'(kq(2600));

  localparam logic signed [XW-1:0] K339 = XW'(kq(339));
  localparam logic signed [XW-1:0] K466 = XW'(kq(466));
  localparam logic signed [XW-1:0] K679 = XW'(kq(679));
  localparam logic signed [XW-1:0] K331 = XW'(kq(331));
  localparam logic signed [XW-1:0] K985 = XW'(kq(985));

  localparam logic signed [DATA_W-1:0] K129 = DATA_W'(kq(129));
  localparam logic signed [DATA_W-1:0] K84  = DATA_W'(kq(84));
  localparam logic signed [DATA_W-1:0] K47  = DATA_W'(kq(47));
  localparam logic signed [DATA_W-1:0] K134 = DATA_W'(kq(134));
  localparam logic signed [DATA_W-1:0] K130 = DATA_W'(kq(130));

  localparam int TAB_X_MILLI [16] = '{
    1000, 2000, 2500, 3000, 4000, 5000, 6000, 7000, 8000, 9000,
    9000, 9000, 9000, 9000, 9000, 9000
  };
  localparam int TAB_Y_MILLI [16] = '{
    550, 600, 630, 680, 800, 880, 950, 1020, 1200, 1400,
    1400, 1400, 1400, 1400, 1400, 1400
  };

  typedef logic signed [XW-1:0]     xq_arr_t [TABLE_POINTS];
  typedef logic signed [DATA_W-1:0] dq_arr_t [TABLE_POINTS];
  typedef logic        [SH_W-1:0]   sh_arr_t [TABLE_POINTS];

  function automatic xq_arr_t build_tab_x();
    xq_arr_t r;
    for (int i = 0; i < TABLE_POINTS; i++) r[i] = XW'(kq(TAB_X_MILLI[i]));
    return r;
  endfunction

  function automatic xq_arr_t build_tab_y();
    xq_arr_t r;
    for (int i = 0; i < TABLE_POINTS; i++) r[i] = XW'(kq(TAB_Y_MILLI[i]));
    return r;
  endfunction

  localparam xq_arr_t TAB_XQ = build_tab_x();
  localparam xq_arr_t TAB_YQ = build_tab_y();

  // per segment i (x[i-1]..x[i]); entry 0 is never selected
  function automatic xq_arr_t build_seg_x0();
    xq_arr_t r;
    r[0] = TAB_XQ[0];
    for (int i = 1; i < TABLE_POINTS; i++) r[i] = TAB_XQ[i-1];
    return r;
  endfunction

  function automatic xq_arr_t build_seg_y0();
    xq_arr_t r;
    r[0] = TAB_YQ[0];
    for (int i = 1; i < TABLE_POINTS; i++) r[i] = TAB_YQ[i-1];
    return r;
  endfunction

  // spans are whole or half units, so the segment divide is a shift
  function automatic dq_arr_t build_seg_dy();
    dq_arr_t r;
    longint  span;
    r[0] = '0;
    for (int i = 1; i < TABLE_POINTS; i++) begin
      span = kq(TAB_X_MILLI[i]) - kq(TAB_X_MILLI[i-1]);
      r[i] = (span > 0) ? DATA_W'(kq(TAB_Y_MILLI[i]) - kq(TAB_Y_MILLI[i-1])) : '0;
    end
    return r;
  endfunction

  function automatic sh_arr_t build_seg_sh();
    sh_arr_t r;
    longint  span;
    r[0] = '0;
    for (int i = 1; i < TABLE_POINTS; i++) begin
      span = kq(TAB_X_MILLI[i]) - kq(TAB_X_MILLI[i-1]);
      r[i] = (span > 0) ? SH_W'($clog2(span)) : '0;
    end
    return r;
  endfunction

  localparam xq_arr_t SEG_X0 = build_seg_x0();
  localparam xq_arr_t SEG_Y0 = build_seg_y0();
  localparam dq_arr_t SEG_DY = build_seg_dy();
  localparam sh_arr_t SEG_SH = build_seg_sh();

endpackage

// ===== src/smre_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Payload types come from smre_pkg at instantiation.
interface smre_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/stellar_mass_relation_evaluator.sv =====
// Stellar mass relation evaluator: six-stage pipeline, one transfer per cycle unless the output stalls.
// Stages: compare/segment, square or age product, operand select, products,
// rounding, sum and saturate. Bubbles are squeezed out on output stall.
// Reset (sync, rst_n low) clears valid bits and the config registers.
// Uses smre_pkg and smre_stream_if.
module stellar_mass_relation_evaluator (
  input  logic                                clk,
  input  logic                                rst_n,
  smre_stream_if.sink                         in_stream,
  smre_stream_if.source                       out_stream,
  input  logic                                cfg_we,
  input  logic [smre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smre_pkg::DATA_W-1:0]         cfg_wdata
);

  localparam int NSTG   = 6;
  localparam int DATA_W = smre_pkg::DATA_W;
  localparam int XW     = smre_pkg::XW;
  localparam int P1W    = smre_pkg::P1W;
  localparam int YW     = smre_pkg::YW;
  localparam int LO_W   = smre_pkg::LO_W;
  localparam int HI_W   = smre_pkg::HI_W;
  localparam int P2W    = smre_pkg::P2W;
  localparam int P3W    = smre_pkg::P3W;
  localparam int T3W    = smre_pkg::T3W;
  localparam int SUMW   = smre_pkg::SUMW;
  localparam int SH_W   = smre_pkg::SH_W;
  localparam int SEG_W  = smre_pkg::SEG_W;
  localparam int FB     = smre_pkg::FRAC_BITS;
  localparam int NPTS   = smre_pkg::TABLE_POINTS;

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  // config registers
  logic [smre_pkg::REL_W-1:0] sel_r, sel_nxt;
  logic signed [DATA_W-1:0]   icpt_r, icpt_nxt;
  logic signed [DATA_W-1:0]   slope_r, slope_nxt;
  logic signed [DATA_W-1:0]   curve_r, curve_nxt;
  logic signed [DATA_W-1:0]   age_r, age_nxt;

  // handshake
  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG-1:0] en;
  logic            in_xfer, out_xfer;

  // stage 1
  logic signed [XW-1:0] s1_mx_r, s1_mx_nxt;
  logic signed [XW-1:0] s1_d3_r, s1_d3_nxt;
  logic                 s1_gt4_r, s1_gt4_nxt, s1_lt4_r, s1_lt4_nxt;
  logic                 s1_lo_r, s1_lo_nxt, s1_hi_r, s1_hi_nxt;
  logic [SEG_W-1:0]     s1_seg_r, s1_seg_nxt;

  // stage 2
  logic signed [P1W-1:0] s2_p1_r, s2_p1_nxt;
  logic signed [XW-1:0]  s2_mx_r, s2_d3_r;
  logic                  s2_gt4_r, s2_lt4_r, s2_lo_r, s2_hi_r;
  logic [SEG_W-1:0]      s2_seg_r;
  logic signed [XW-1:0]  op_a, op_b;

  // stage 3
  logic signed [P1W-1:0]    p1_rnd;
  logic signed [YW-1:0]     r1;
  logic signed [DATA_W-1:0] s3_coef_r, s3_coef_nxt;
  logic signed [XW-1:0]     s3_x_r, s3_x_nxt;
  logic signed [YW-1:0]     s3_y_r, s3_y_nxt;
  logic signed [XW-1:0]     s3_t1_r, s3_t1_nxt;
  logic [SH_W-1:0]          s3_sh_r, s3_sh_nxt;
  logic                     s3_err_r, s3_err_nxt;

  // stage 4
  logic signed [P2W-1:0]           s4_p2_r, s4_p2_nxt;
  logic signed [DATA_W+LO_W:0]     s4_p3lo_r, s4_p3lo_nxt;
  logic signed [DATA_W+HI_W-1:0]   s4_p3hi_r, s4_p3hi_nxt;
  logic signed [XW-1:0]            s4_t1_r;
  logic [SH_W-1:0]                 s4_sh_r;
  logic                            s4_err_r;

  // stage 5
  logic [P2W-1:0]        half2;
  logic signed [P2W-1:0] p2_rnd;
  logic signed [P3W-1:0] p3_rnd;
  logic signed [P2W-1:0] s5_t2_r, s5_t2_nxt;
  logic signed [T3W-1:0] s5_t3_r, s5_t3_nxt;
  logic signed [XW-1:0]  s5_t1_r;
  logic                  s5_err_r;

  // stage 6
  logic signed [SUMW-1:0]   sum;
  logic signed [DATA_W-1:0] out_mass_r, out_mass_nxt;
  logic                     out_err_r;

  // ---------------- configuration ----------------
  always_comb begin
    sel_nxt   = sel_r;
    icpt_nxt  = icpt_r;
    slope_nxt = slope_r;
    curve_nxt = curve_r;
    age_nxt   = age_r;
    if (cfg_we) begin
      unique case (cfg_index)
        smre_pkg::CFG_SELECT:    sel_nxt   = cfg_wdata[smre_pkg::REL_W-1:0];
        smre_pkg::CFG_INTERCEPT: icpt_nxt  = cfg_wdata;
        smre_pkg::CFG_SLOPE:     slope_nxt = cfg_wdata;
        smre_pkg::CFG_CURVE:     curve_nxt = cfg_wdata;
        smre_pkg::CFG_AGE:       age_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      icpt_r  <= '0;
      slope_r <= '0;
      curve_r <= '0;
      age_r   <= '0;
    end else begin
      sel_r   <= sel_nxt;
      icpt_r  <= icpt_nxt;
      slope_r <= slope_nxt;
      curve_r <= curve_nxt;
      age_r   <= age_nxt;
    end
  end

  // ---------------- valid chain ----------------
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_stream.ready;
    for (int k = NSTG - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
    v_nxt[0] = en[0] ? in_stream.valid : v_r[0];
    for (int k = 1; k < NSTG; k++) v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  assign in_stream.ready = en[0];
  assign in_xfer  = in_stream.valid && in_stream.ready;
  assign out_xfer = out_stream.valid && out_stream.ready;

  // ---------------- stage 1: compares, segment ----------------
  always_comb begin
    s1_mx_nxt  = XW'(in_stream.payload.initial_mass);
    s1_d3_nxt  = s1_mx_nxt - smre_pkg::Q_THREE;
    s1_gt4_nxt = s1_mx_nxt > smre_pkg::Q_FOUR;
    s1_lt4_nxt = s1_mx_nxt < smre_pkg::Q_FOUR;
    s1_lo_nxt  = s1_mx_nxt <= smre_pkg::TAB_XQ[0];
    s1_hi_nxt  = s1_mx_nxt >= smre_pkg::TAB_XQ[NPTS-1];
    s1_seg_nxt = SEG_W'(1);
    for (int j = 2; j < NPTS; j++) begin
      if (s1_mx_nxt > smre_pkg::TAB_XQ[j-1]) s1_seg_nxt = SEG_W'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_mx_r  <= s1_mx_nxt;
      s1_d3_r  <= s1_d3_nxt;
      s1_gt4_r <= s1_gt4_nxt;
      s1_lt4_r <= s1_lt4_nxt;
      s1_lo_r  <= s1_lo_nxt;
      s1_hi_r  <= s1_hi_nxt;
      s1_seg_r <= s1_seg_nxt;
    end
  end

  // ---------------- stage 2: square or age product ----------------
  always_comb begin
    if (sel_r == smre_pkg::REL_QUAD) begin
      op_a = s1_d3_r;
      op_b = s1_d3_r;
    end else begin
      op_a = XW'(age_r);
      op_b = smre_pkg::K2600;
    end
    s2_p1_nxt = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_p1_r  <= s2_p1_nxt;
      s2_mx_r  <= s1_mx_r;
      s2_d3_r  <= s1_d3_r;
      s2_gt4_r <= s1_gt4_r;
      s2_lt4_r <= s1_lt4_r;
      s2_lo_r  <= s1_lo_r;
      s2_hi_r  <= s1_hi_r;
      s2_seg_r <= s1_seg_r;
    end
  end

  // ---------------- stage 3: relation decode ----------------
  always_comb begin
    p1_rnd      = s2_p1_r + P1W'(smre_pkg::HALF_Q);
    r1          = $signed(p1_rnd[P1W-1:FB]);
    s3_coef_nxt = '0;
    s3_x_nxt    = '0;
    s3_y_nxt    = '0;
    s3_t1_nxt   = '0;
    s3_sh_nxt   = SH_W'(FB);
    s3_err_nxt  = 1'b0;
    unique case (sel_r)
      smre_pkg::REL_TABLE: begin
        if (s2_lo_r) begin
          s3_t1_nxt = smre_pkg::TAB_YQ[0];
        end else if (s2_hi_r) begin
          s3_t1_nxt = smre_pkg::TAB_YQ[NPTS-1];
        end else begin
          s3_t1_nxt   = smre_pkg::SEG_Y0[s2_seg_r];
          s3_coef_nxt = smre_pkg::SEG_DY[s2_seg_r];
          s3_x_nxt    = s2_mx_r - smre_pkg::SEG_X0[s2_seg_r];
          s3_sh_nxt   = smre_pkg::SEG_SH[s2_seg_r];
        end
      end
      smre_pkg::REL_LIN_A: begin
        s3_t1_nxt   = smre_pkg::K339;
        s3_coef_nxt = smre_pkg::K129;
        s3_x_nxt    = s2_mx_r;
      end
      smre_pkg::REL_LIN_B: begin
        s3_t1_nxt   = smre_pkg::K466;
        s3_coef_nxt = smre_pkg::K84;
        s3_x_nxt    = s2_mx_r;
      end
      smre_pkg::REL_BROKEN: begin
        s3_t1_nxt   = s2_gt4_r ? smre_pkg::K679 : smre_pkg::K331;
        s3_coef_nxt = s2_gt4_r ? smre_pkg::K47 : smre_pkg::K134;
        s3_x_nxt    = s2_mx_r;
      end
      smre_pkg::REL_SHIFT3: begin
        s3_t1_nxt   = XW'(icpt_r);
        s3_coef_nxt = slope_r;
        s3_x_nxt    = s2_d3_r;
      end
      smre_pkg::REL_PLAIN: begin
        s3_t1_nxt   = XW'(icpt_r);
        s3_coef_nxt = slope_r;
        s3_x_nxt    = s2_mx_r;
      end
      smre_pkg::REL_AGE: begin
        s3_t1_nxt   = XW'(icpt_r);
        s3_coef_nxt = slope_r;
        s3_x_nxt    = s2_mx_r - smre_pkg::K27000 + XW'(r1);
      end
      smre_pkg::REL_SHIFT5: begin
        s3_t1_nxt   = XW'(icpt_r);
        s3_coef_nxt = slope_r;
        s3_x_nxt    = s2_mx_r - smre_pkg::Q_FIVE;
      end
      smre_pkg::REL_EDITED: begin
        s3_t1_nxt   = smre_pkg::K985;
        s3_coef_nxt = smre_pkg::K130;
        s3_x_nxt    = s2_mx_r - smre_pkg::Q_TWO;
      end
      smre_pkg::REL_QUAD: begin
        s3_t1_nxt   = XW'(icpt_r);
        s3_coef_nxt = slope_r;
        s3_x_nxt    = s2_d3_r;
        s3_y_nxt    = r1;
      end
      smre_pkg::REL_SPLIT: begin
        s3_t1_nxt   = XW'(icpt_r);
        s3_coef_nxt = slope_r;
        if (s2_lt4_r) begin
          s3_x_nxt = s2_d3_r;
        end else begin
          s3_x_nxt = smre_pkg::Q_ONE;
          s3_y_nxt = YW'(s2_mx_r - smre_pkg::Q_FOUR);
        end
      end
      default: s3_err_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_coef_r <= s3_coef_nxt;
      s3_x_r    <= s3_x_nxt;
      s3_y_r    <= s3_y_nxt;
      s3_t1_r   <= s3_t1_nxt;
      s3_sh_r   <= s3_sh_nxt;
      s3_err_r  <= s3_err_nxt;
    end
  end

  // ---------------- stage 4: products ----------------
  always_comb begin
    s4_p2_nxt   = s3_coef_r * s3_x_r;
    s4_p3lo_nxt = curve_r * $signed({1'b0, s3_y_r[LO_W-1:0]});
    s4_p3hi_nxt = curve_r * $signed(s3_y_r[YW-1:LO_W]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_p2_r   <= s4_p2_nxt;
      s4_p3lo_r <= s4_p3lo_nxt;
      s4_p3hi_r <= s4_p3hi_nxt;
      s4_t1_r   <= s3_t1_r;
      s4_sh_r   <= s3_sh_r;
      s4_err_r  <= s3_err_r;
    end
  end

  // ---------------- stage 5: round half up ----------------
  always_comb begin
    half2     = (P2W'(1) << s4_sh_r) >> 1;
    p2_rnd    = s4_p2_r + $signed(half2);
    s5_t2_nxt = p2_rnd >>> s4_sh_r;
    p3_rnd    = (P3W'(s4_p3hi_r) <<< LO_W) + P3W'(s4_p3lo_r) + P3W'(smre_pkg::HALF_Q);
    s5_t3_nxt = $signed(p3_rnd[P3W-1:FB]);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_t2_r  <= s5_t2_nxt;
      s5_t3_r  <= s5_t3_nxt;
      s5_t1_r  <= s4_t1_r;
      s5_err_r <= s4_err_r;
    end
  end

  // ---------------- stage 6: sum, saturate ----------------
  always_comb begin
    sum = SUMW'(s5_t1_r) + SUMW'(s5_t2_r) + SUMW'(s5_t3_r);
    if (sum > SAT_HI)      out_mass_nxt = SAT_HI[DATA_W-1:0];
    else if (sum < SAT_LO) out_mass_nxt = SAT_LO[DATA_W-1:0];
    else                   out_mass_nxt = sum[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_mass_r <= out_mass_nxt;
      out_err_r  <= s5_err_r;
    end
  end

  assign out_stream.valid              = v_r[NSTG-1];
  assign out_stream.payload.final_mass = out_mass_r;
  assign out_stream.payload.mode_error = out_err_r;

  // ---------------- assertions ----------------
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(v_r) ==
      $past($countones(v_r)) + int'($past(in_xfer)) - int'($past(out_xfer)))
    else $error("pipeline occupancy does not match transfers");

  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_stream.ready)
    else $error("input stalled while pipeline has a free stage");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid && out_stream.payload.mode_error |->
      out_stream.payload.final_mass == '0)
    else $error("mode error with nonzero mass");

endmodule

// ===== dv/smre_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the stellar mass relation evaluator: tracks config writes,
// predicts each remnant mass from the accepted initial mass, checks results in order.
// Depends on smre_pkg for payload types, relation and register codes.
module smre_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  smre_pkg::in_item_t                 in_item,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  smre_pkg::out_item_t                out_item,
  input  logic                               cfg_we,
  input  logic [smre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smre_pkg::DATA_W-1:0]        cfg_wdata,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked_count,
  output int                                 flagged_count
);

  localparam int     FRAC_BITS = smre_pkg::FRAC_BITS;
  localparam int     DATA_W   = smre_pkg::DATA_W;
  localparam int     REL_W    = smre_pkg::REL_W;
  localparam longint UNIT     = 64'sd1 <<< FRAC_BITS;
  localparam longint PROD_CAP = 64'sd1 <<< 46;
  localparam longint MASS_MAX = 64'sd8388607;
  localparam longint MASS_MIN = -64'sd8388608;
  localparam int     KNOTS    = 10;
  localparam int     MAX_PRINTS = 40;

  localparam int KNOT_X_MILLI [KNOTS] = '{
    1000, 2000, 2500, 3000, 4000, 5000, 6000, 7000, 8000, 9000
  };
  localparam int KNOT_Y_MILLI [KNOTS] = '{
    550, 600, 630, 680, 800, 880, 950, 1020, 1200, 1400
  };

  logic [REL_W-1:0]    rel_sel;
  longint              coef_a;
  longint              coef_b;
  longint              coef_c;
  longint              age_term;
  smre_pkg::out_item_t remnant_q [$];

  function automatic longint q_from_milli(longint milli);
    return (milli * UNIT + 500) / 1000;
  endfunction

  // round to nearest, halves toward +inf
  function automatic longint q_round(longint p);
    return (p + (UNIT >>> 1)) >>> FRAC_BITS;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return q_round(a * b);
  endfunction

  function automatic longint interp_knots(longint m);
    longint x0, x1, y0, y1, span;
    if (m <= q_from_milli(KNOT_X_MILLI[0])) return q_from_milli(KNOT_Y_MILLI[0]);
    if (m >= q_from_milli(KNOT_X_MILLI[KNOTS-1])) return q_from_milli(KNOT_Y_MILLI[KNOTS-1]);
    for (int i = 1; i < KNOTS; i++) begin
      x0 = q_from_milli(KNOT_X_MILLI[i-1]);
      x1 = q_from_milli(KNOT_X_MILLI[i]);
      if (x0 <= m && m <= x1) begin
        y0 = q_from_milli(KNOT_Y_MILLI[i-1]);
        y1 = q_from_milli(KNOT_Y_MILLI[i]);
        span = x1 - x0;
        if (span <= 0) return y0;
        return y0 + ((y1 - y0) * (m - x0) * 2 + span) / (2 * span);
      end
    end
    return 0;
  endfunction

  function automatic smre_pkg::out_item_t predict_remnant(logic signed [DATA_W-1:0] mass);
    longint              m, r, d, sq, curve_term;
    smre_pkg::out_item_t res;
    m = mass;
    r = 0;
    res.mode_error = 1'b0;
    case (rel_sel)
      smre_pkg::REL_TABLE:  r = interp_knots(m);
      smre_pkg::REL_LIN_A:  r = q_from_milli(339) + q_mul(q_from_milli(129), m);
      smre_pkg::REL_LIN_B:  r = q_from_milli(466) + q_mul(q_from_milli(84), m);
      smre_pkg::REL_BROKEN: begin
        if (m > 4 * UNIT) r = q_from_milli(679) + q_mul(q_from_milli(47), m);
        else r = q_from_milli(331) + q_mul(q_from_milli(134), m);
      end
      smre_pkg::REL_SHIFT3: r = coef_a + q_mul(coef_b, m - 3 * UNIT);
      smre_pkg::REL_PLAIN:  r = coef_a + q_mul(coef_b, m);
      smre_pkg::REL_AGE: begin
        d = m - q_from_milli(27000) + q_mul(age_term, q_from_milli(2600));
        r = coef_a + q_mul(coef_b, d);
      end
      smre_pkg::REL_SHIFT5: r = coef_a + q_mul(coef_b, m - 5 * UNIT);
      smre_pkg::REL_EDITED: r = q_from_milli(985) + q_mul(q_from_milli(130), m - 2 * UNIT);
      smre_pkg::REL_QUAD: begin
        d = m - 3 * UNIT;
        sq = q_round(d * d);
        curve_term = q_mul(coef_c, sq);
        if (curve_term > PROD_CAP) curve_term = PROD_CAP;
        if (curve_term < -PROD_CAP) curve_term = -PROD_CAP;
        r = coef_a + q_mul(coef_b, d) + curve_term;
      end
      smre_pkg::REL_SPLIT: begin
        if (m < 4 * UNIT) r = coef_a + q_mul(coef_b, m - 3 * UNIT);
        else r = coef_a + q_mul(coef_b, UNIT) + q_mul(coef_c, m - 4 * UNIT);
      end
      // rotated form and undefined selects
      default: begin
        res.mode_error = 1'b1;
        r = 0;
      end
    endcase
    if (r > MASS_MAX) r = MASS_MAX;
    if (r < MASS_MIN) r = MASS_MIN;
    res.final_mass = r[DATA_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    if (fail_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d (result #%0d)",
               $realtime, what, want, got, checked_count);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    checked_count = 0;
    flagged_count = 0;
  end

  always @(posedge clk) begin
    smre_pkg::out_item_t want;
    if (!rst_n) begin
      rel_sel = smre_pkg::REL_TABLE;
      coef_a = 0;
      coef_b = 0;
      coef_c = 0;
      age_term = 0;
      remnant_q.delete();
    end else begin
      if (cfg_we) begin
        case (smre_pkg::cfg_reg_t'(cfg_index))
          smre_pkg::CFG_SELECT:    rel_sel = cfg_wdata[REL_W-1:0];
          smre_pkg::CFG_INTERCEPT: coef_a = $signed(cfg_wdata);
          smre_pkg::CFG_SLOPE:     coef_b = $signed(cfg_wdata);
          smre_pkg::CFG_CURVE:     coef_c = $signed(cfg_wdata);
          smre_pkg::CFG_AGE:       age_term = $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (in_valid && in_ready) remnant_q.push_back(predict_remnant(in_item.initial_mass));
      if (out_valid && out_ready) begin
        if (remnant_q.size() == 0) begin
          report_mismatch("unexpected transfer, final_mass", 0, out_item.final_mass);
        end else begin
          want = remnant_q.pop_front();
          if (out_item.final_mass !== want.final_mass)
            report_mismatch("final_mass", want.final_mass, out_item.final_mass);
          if (out_item.mode_error !== want.mode_error)
            report_mismatch("mode_error", want.mode_error, out_item.mode_error);
          if (want.mode_error) flagged_count++;
        end
        checked_count++;
      end
    end
    pending = remnant_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top-level bench for stellar_mass_relation_evaluator: clock, reset, config writes,
// initial-mass stimulus with random idling on both sides, and the final verdict.
// Depends on smre_pkg, smre_stream_if, the DUT and smre_checker.
module testbench;

  localparam int DATA_W       = smre_pkg::DATA_W;
  localparam int REL_W        = smre_pkg::REL_W;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 30;
  localparam int PHASE_ITEMS  = 15;
  localparam int TAIL_CYCLES  = 12;
  localparam logic [REL_W-1:0] REL_UNDEF_LAST = 4'd15;
  localparam logic signed [DATA_W-1:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 24'sh800000;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [smre_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]              cfg_wdata;

  int fail_count, pending, checked_count, flagged_count;
  int send_idle_pct, recv_idle_pct;
  int items_sent;
  int cycle_count = 0;

  logic signed [DATA_W-1:0] table_probe [14] = '{
    -24'sd8388608, 24'sd8388607, 24'sd0, 24'sd65535, 24'sd65536, 24'sd65537,
    24'sd98304, 24'sd163840, 24'sd180224, 24'sd262144, 24'sd425984,
    24'sd589823, 24'sd589824, 24'sd589825
  };
  int knot_milli [10] = '{1000, 2000, 2500, 3000, 4000, 5000, 6000, 7000, 8000, 9000};

  smre_stream_if #(.payload_t(smre_pkg::in_item_t))  in_ch ();
  smre_stream_if #(.payload_t(smre_pkg::out_item_t)) out_ch ();

  stellar_mass_relation_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  smre_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_item       (in_ch.payload),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_item      (out_ch.payload),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .flagged_count (flagged_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(smre_pkg::cfg_reg_t idx, logic [DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic load_config(logic [REL_W-1:0] sel, logic signed [DATA_W-1:0] a,
                             logic signed [DATA_W-1:0] b, logic signed [DATA_W-1:0] c,
                             logic signed [DATA_W-1:0] g);
    write_reg(smre_pkg::CFG_SELECT, DATA_W'(sel));
    write_reg(smre_pkg::CFG_INTERCEPT, a);
    write_reg(smre_pkg::CFG_SLOPE, b);
    write_reg(smre_pkg::CFG_CURVE, c);
    write_reg(smre_pkg::CFG_AGE, g);
    cfg_we <= 1'b0;
  endtask

  task automatic send_mass(logic signed [DATA_W-1:0] m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_mass();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return DATA_W'($urandom);
    if (pick < 65) return DATA_W'($urandom_range(786432));
    if (pick < 80)
      return DATA_W'(knot_milli[$urandom_range(9)] * 65536 / 1000 + $urandom_range(8) - 4);
    if (pick < 90) return -DATA_W'($urandom_range(786432));
    case ($urandom_range(3))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_coef(int style, bit high);
    case (style)
      0: return DATA_W'($urandom_range(524288)) - DATA_W'(262144);
      1: return DATA_W'($urandom);
      2: return high ? Q_MAX : Q_MIN;
      default: return ($urandom_range(1) != 0) ? '0 : DATA_W'($urandom_range(131072));
    endcase
  endfunction

  initial begin
    int style;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = smre_pkg::CFG_SELECT;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    items_sent    = 0;
    send_idle_pct = 14;
    recv_idle_pct = 84;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: table knots and clamps, breaks at 4, saturation, error selects
    load_config(smre_pkg::REL_TABLE, '0, '0, '0, '0);
    foreach (table_probe[i]) send_mass(table_probe[i]);
    drain();
    load_config(smre_pkg::REL_BROKEN, '0, '0, '0, '0);
    send_mass(24'sd262143);
    send_mass(24'sd262144);
    send_mass(24'sd262145);
    drain();
    load_config(smre_pkg::REL_SPLIT, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_mass(24'sd262143);
    send_mass(24'sd262144);
    send_mass(Q_MAX);
    drain();
    load_config(smre_pkg::REL_QUAD, Q_MIN, Q_MIN, Q_MAX, Q_MIN);
    send_mass(Q_MIN);
    send_mass(Q_MAX);
    drain();
    load_config(smre_pkg::REL_ROTATED, '0, '0, '0, '0);
    send_mass(24'sd131072);
    drain();
    load_config(REL_UNDEF_LAST, '0, '0, '0, '0);
    send_mass(24'sd131072);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 10) begin
        send_idle_pct = 14;
        recv_idle_pct = 84;
      end else if (p < 20) begin
        send_idle_pct = 84;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      style = (p + p / 16) % 4;
      load_config(REL_W'(p % 16),
                  pick_coef(style, ((p / 4) % 2) != 0),
                  pick_coef(style, ((p / 4) % 2) != 0),
                  pick_coef(style, ((p / 4) % 2) == 0),
                  pick_coef(style, ((p / 4) % 2) != 0));
      repeat (PHASE_ITEMS) send_mass(pick_mass());
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d initial masses across every relation select, register extremes and",
             items_sent);
    $display("three idling mixes; %0d remnant results compared, %0d flagged unsupported",
             checked_count, flagged_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
